### hdl/sandpile_toppling_with_odometer_unit_defines.svh
// Assertion macros for the sandpile odometer unit.
// Uses the clk and rst_n names of the module that includes it.
`ifndef SANDPILE_TOPPLING_WITH_ODOMETER_UNIT_DEFINES_SVH
`define SANDPILE_TOPPLING_WITH_ODOMETER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SPU_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define SPU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPU_ASSERT_ALWAYS(label, expr)
`define SPU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/spu_pkg.sv
// Package for the sandpile odometer unit: sequencer states and site word.
// No dependencies.
`timescale 1ns / 1ps
package spu_pkg;
    localparam int HEIGHT_W = 8;
    localparam int ODO_W    = 32;
    localparam int GRAIN_W  = 6;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_ADD, S_G_RD, S_G_WR, S_POP,
        S_SITE_RD, S_SITE_EX, S_NB, S_Q_RD, S_Q_EX
    } state_t;

    typedef enum logic [1:0] {
        PH_A, PH_B, PH_NB
    } phase_t;

    typedef struct packed {
        logic                mark;
        logic [ODO_W-1:0]    odo;
        logic [HEIGHT_W-1:0] height;
    } site_word_t;
endpackage

### hdl/spu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module spu_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 41
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### hdl/sandpile_toppling_with_odometer_unit.sv
// Top level of the sandpile odometer unit: sequencer, site RAM and worklist.
// Depends on spu_pkg, spu_ram and the assertion macro header.
//
// Usage: an input request (restart, amount_a, amount_b, query_site) is taken
// when in_valid and in_ready are high; one result request (odometer_value,
// site_height, boundary_hit) follows on the out channel. cfg_data loads the
// core heights register; write it only while the unit is idle.
// Sequence: a restart first runs a clearing pass over every site and four core
// loads; then each nonzero amount is added (amount_a to the middle site,
// amount_b to its right neighbor), every worklist entry is popped and
// toppled, feeding each neighbor that it has (four for an interior site), and
// the query site is read into the output register.
// Throughput: one request in flight; in_ready is high only while idle.
// Reset: a clearing pass zeroes every site; no input request is taken during
// it (configuration writes are).
// Stall: a finished result waits in the output register; while it is not
// taken the unit holds the next result and stays busy.
`timescale 1ns / 1ps
`include "sandpile_toppling_with_odometer_unit_defines.svh"
module sandpile_toppling_with_odometer_unit #(
    parameter int GRID_SIDE = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    input  logic [1:0]  amount_a,
    input  logic [1:0]  amount_b,
    input  logic [13:0] query_site,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] odometer_value,
    output logic [1:0]  site_height,
    output logic        boundary_hit
);
    localparam int SITE_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int SITE_W     = $clog2(SITE_COUNT);
    localparam int RC_W       = $clog2(GRID_SIDE);
    localparam int CNT_W      = $clog2(SITE_COUNT + 1);
    localparam int WORD_W     = $bits(spu_pkg::site_word_t);
    localparam int QCMP_W     = 32;
    localparam logic [RC_W-1:0]   MID      = RC_W'(GRID_SIDE / 2);
    localparam logic [RC_W-1:0]   LAST_RC  = RC_W'(GRID_SIDE - 1);
    localparam logic [SITE_W-1:0] SIDE     = SITE_W'(GRID_SIDE);
    localparam logic [SITE_W-1:0] LAST_SITE = SITE_W'(SITE_COUNT - 1);
    localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(SITE_COUNT);

    spu_pkg::state_t state_reg, state_next;
    spu_pkg::phase_t phase_reg, phase_next;

    logic [7:0]              core_reg;
    logic                    restart_reg, restart_next;
    logic [1:0]              amt_a_reg, amt_a_next;
    logic [1:0]              amt_b_reg, amt_b_next;
    logic [13:0]             query_reg, query_next;
    logic [SITE_W-1:0]       clr_reg, clr_next;
    logic [1:0]              load_reg, load_next;
    logic [1:0]              nb_reg, nb_next;
    logic [RC_W-1:0]         cur_row_reg, cur_row_next, cur_col_reg, cur_col_next;
    logic [RC_W-1:0]         tgt_row_reg, tgt_row_next, tgt_col_reg, tgt_col_next;
    logic [spu_pkg::GRAIN_W-1:0] grains_reg, grains_next;
    logic [CNT_W-1:0]        head_reg, head_next, count_reg, count_next;
    logic                    bound_reg, bound_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             odo_out_reg, odo_out_next;
    logic [1:0]              height_out_reg, height_out_next;
    logic                    bnd_out_reg, bnd_out_next;

    logic                    ram_we, ram_re;
    logic [SITE_W-1:0]       ram_waddr, ram_raddr;
    spu_pkg::site_word_t     ram_wdata, ram_q;
    logic [WORD_W-1:0]       ram_q_bits;
    logic                    fifo_we, fifo_re;
    logic [SITE_W-1:0]       fifo_waddr, fifo_raddr;
    logic [2*RC_W-1:0]       fifo_wdata, fifo_q;

    logic [SITE_W-1:0]       tgt_addr, cur_addr;
    logic [CNT_W:0]          tail_sum;
    logic [CNT_W-1:0]        tail;
    logic [CNT_W:0]          head_inc;
    logic [spu_pkg::HEIGHT_W:0] hsum;
    logic [spu_pkg::HEIGHT_W-1:0] hnew;
    logic                    push;
    logic [spu_pkg::GRAIN_W-1:0] topples;
    logic [spu_pkg::ODO_W:0] osum;
    logic                    in_range;

    assign ram_q     = spu_pkg::site_word_t'(ram_q_bits);
    assign tgt_addr  = SITE_W'(tgt_row_reg) * SIDE + SITE_W'(tgt_col_reg);
    assign cur_addr  = SITE_W'(cur_row_reg) * SIDE + SITE_W'(cur_col_reg);
    assign tail_sum  = {1'b0, head_reg} + {1'b0, count_reg};
    assign tail      = (tail_sum >= {1'b0, COUNT_MAX}) ? CNT_W'(tail_sum - {1'b0, COUNT_MAX})
                                                       : CNT_W'(tail_sum);
    assign head_inc  = {1'b0, head_reg} + (CNT_W+1)'(1);
    assign hsum      = {1'b0, ram_q.height} + (spu_pkg::HEIGHT_W+1)'(grains_reg);
    assign hnew      = hsum[spu_pkg::HEIGHT_W] ? '1 : hsum[spu_pkg::HEIGHT_W-1:0];
    assign push      = (hnew >= spu_pkg::HEIGHT_W'(4)) && !ram_q.mark && (count_reg < COUNT_MAX);
    assign topples   = ram_q.height[spu_pkg::HEIGHT_W-1:2];
    assign osum      = {1'b0, ram_q.odo} + (spu_pkg::ODO_W+1)'(topples);
    assign in_range  = QCMP_W'(query_reg) < QCMP_W'(SITE_COUNT);

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == spu_pkg::S_IDLE);
    assign out_valid      = out_valid_reg;
    assign odometer_value = odo_out_reg;
    assign site_height    = height_out_reg;
    assign boundary_hit   = bnd_out_reg;

    spu_ram #(.DEPTH(SITE_COUNT), .WIDTH(WORD_W)) u_site_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q_bits)
    );

    spu_ram #(.DEPTH(SITE_COUNT), .WIDTH(2*RC_W)) u_work_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .re    (fifo_re),
        .raddr (fifo_raddr),
        .rdata (fifo_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spu_pkg::S_CLEAR:
            begin
                if (clr_reg == LAST_SITE)
                begin
                    state_next = restart_reg ? spu_pkg::S_LOAD : spu_pkg::S_IDLE;
                end
            end
            spu_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = restart ? spu_pkg::S_CLEAR : spu_pkg::S_ADD;
                end
            end
            spu_pkg::S_LOAD:
            begin
                if (load_reg == 2'd3)
                begin
                    state_next = spu_pkg::S_ADD;
                end
            end
            spu_pkg::S_ADD:
            begin
                if (phase_reg == spu_pkg::PH_A)
                begin
                    state_next = (amt_a_reg != 2'd0) ? spu_pkg::S_G_RD : spu_pkg::S_ADD;
                end
                else
                begin
                    state_next = (amt_b_reg != 2'd0) ? spu_pkg::S_G_RD : spu_pkg::S_POP;
                end
            end
            spu_pkg::S_G_RD:
            begin
                state_next = spu_pkg::S_G_WR;
            end
            spu_pkg::S_G_WR:
            begin
                case (phase_reg)
                    spu_pkg::PH_A:  state_next = spu_pkg::S_ADD;
                    spu_pkg::PH_B:  state_next = spu_pkg::S_POP;
                    default:        state_next = (nb_reg == 2'd3) ? spu_pkg::S_POP
                                                                  : spu_pkg::S_NB;
                endcase
            end
            spu_pkg::S_POP:
            begin
                state_next = (count_reg == '0) ? spu_pkg::S_Q_RD : spu_pkg::S_SITE_RD;
            end
            spu_pkg::S_SITE_RD:
            begin
                state_next = spu_pkg::S_SITE_EX;
            end
            spu_pkg::S_SITE_EX:
            begin
                state_next = (topples == '0) ? spu_pkg::S_POP : spu_pkg::S_NB;
            end
            spu_pkg::S_NB:
            begin
                case (nb_reg)
                    2'd0:    state_next = (cur_row_reg != '0) ? spu_pkg::S_G_RD : spu_pkg::S_NB;
                    2'd1:    state_next = (cur_row_reg != LAST_RC) ? spu_pkg::S_G_RD
                                                                   : spu_pkg::S_NB;
                    2'd2:    state_next = (cur_col_reg != '0) ? spu_pkg::S_G_RD : spu_pkg::S_NB;
                    default: state_next = (cur_col_reg != LAST_RC) ? spu_pkg::S_G_RD
                                                                   : spu_pkg::S_POP;
                endcase
            end
            spu_pkg::S_Q_RD:
            begin
                state_next = spu_pkg::S_Q_EX;
            end
            spu_pkg::S_Q_EX:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = spu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spu_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        phase_next      = phase_reg;
        restart_next    = restart_reg;
        amt_a_next      = amt_a_reg;
        amt_b_next      = amt_b_reg;
        query_next      = query_reg;
        clr_next        = clr_reg;
        load_next       = load_reg;
        nb_next         = nb_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        tgt_row_next    = tgt_row_reg;
        tgt_col_next    = tgt_col_reg;
        grains_next     = grains_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        bound_next      = bound_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        odo_out_next    = odo_out_reg;
        height_out_next = height_out_reg;
        bnd_out_next    = bnd_out_reg;
        ram_we          = 1'b0;
        ram_waddr       = tgt_addr;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = tgt_addr;
        fifo_we         = 1'b0;
        fifo_waddr      = SITE_W'(tail);
        fifo_wdata      = {tgt_row_reg, tgt_col_reg};
        fifo_re         = 1'b0;
        fifo_raddr      = SITE_W'(head_reg);
        case (state_reg)
            spu_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + SITE_W'(1);
            end
            spu_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    restart_next = restart;
                    amt_a_next   = amount_a;
                    amt_b_next   = amount_b;
                    query_next   = query_site;
                    phase_next   = spu_pkg::PH_A;
                    clr_next     = '0;
                    load_next    = '0;
                    if (restart)
                    begin
                        head_next  = '0;
                        count_next = '0;
                        bound_next = 1'b0;
                    end
                end
            end
            spu_pkg::S_LOAD:
            begin
                ram_we = 1'b1;
                case (load_reg)
                    2'd0:
                    begin
                        ram_waddr = SITE_W'(MID) * SIDE + SITE_W'(MID);
                        ram_wdata.height = spu_pkg::HEIGHT_W'(core_reg[7:6]);
                    end
                    2'd1:
                    begin
                        ram_waddr = SITE_W'(MID) * SIDE + SITE_W'(MID) + SITE_W'(1);
                        ram_wdata.height = spu_pkg::HEIGHT_W'(core_reg[5:4]);
                    end
                    2'd2:
                    begin
                        ram_waddr = SITE_W'(MID) * SIDE + SIDE + SITE_W'(MID);
                        ram_wdata.height = spu_pkg::HEIGHT_W'(core_reg[3:2]);
                    end
                    default:
                    begin
                        ram_waddr = SITE_W'(MID) * SIDE + SIDE + SITE_W'(MID) + SITE_W'(1);
                        ram_wdata.height = spu_pkg::HEIGHT_W'(core_reg[1:0]);
                    end
                endcase
                load_next = load_reg + 2'd1;
            end
            spu_pkg::S_ADD:
            begin
                tgt_row_next = MID;
                if (phase_reg == spu_pkg::PH_A)
                begin
                    tgt_col_next = MID;
                    grains_next  = spu_pkg::GRAIN_W'(amt_a_reg);
                    if (amt_a_reg == 2'd0)
                    begin
                        phase_next = spu_pkg::PH_B;
                    end
                end
                else
                begin
                    tgt_col_next = MID + RC_W'(1);
                    grains_next  = spu_pkg::GRAIN_W'(amt_b_reg);
                end
            end
            spu_pkg::S_G_RD:
            begin
                ram_re = 1'b1;
            end
            spu_pkg::S_G_WR:
            begin
                ram_we           = 1'b1;
                ram_wdata.height = hnew;
                ram_wdata.odo    = ram_q.odo;
                ram_wdata.mark   = ram_q.mark || push;
                fifo_we          = push;
                if (push)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (phase_reg == spu_pkg::PH_A)
                begin
                    phase_next = spu_pkg::PH_B;
                end
                nb_next = nb_reg + 2'd1;
            end
            spu_pkg::S_POP:
            begin
                if (count_reg != '0)
                begin
                    fifo_re    = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    head_next  = (head_inc >= {1'b0, COUNT_MAX}) ? '0 : CNT_W'(head_inc);
                end
            end
            spu_pkg::S_SITE_RD:
            begin
                cur_row_next = fifo_q[2*RC_W-1:RC_W];
                cur_col_next = fifo_q[RC_W-1:0];
                ram_re       = 1'b1;
                ram_raddr    = SITE_W'(fifo_q[2*RC_W-1:RC_W]) * SIDE
                               + SITE_W'(fifo_q[RC_W-1:0]);
            end
            spu_pkg::S_SITE_EX:
            begin
                ram_we           = 1'b1;
                ram_waddr        = cur_addr;
                ram_wdata.height = {6'd0, ram_q.height[1:0]};
                ram_wdata.odo    = osum[spu_pkg::ODO_W] ? '1 : osum[spu_pkg::ODO_W-1:0];
                ram_wdata.mark   = 1'b0;
                grains_next      = topples;
                nb_next          = '0;
                if ((topples != '0) && ((cur_row_reg == '0) || (cur_row_reg == LAST_RC) ||
                    (cur_col_reg == '0) || (cur_col_reg == LAST_RC)))
                begin
                    bound_next = 1'b1;
                end
            end
            spu_pkg::S_NB:
            begin
                phase_next   = spu_pkg::PH_NB;
                tgt_row_next = cur_row_reg;
                tgt_col_next = cur_col_reg;
                case (nb_reg)
                    2'd0:    tgt_row_next = cur_row_reg - RC_W'(1);
                    2'd1:    tgt_row_next = cur_row_reg + RC_W'(1);
                    2'd2:    tgt_col_next = cur_col_reg - RC_W'(1);
                    default: tgt_col_next = cur_col_reg + RC_W'(1);
                endcase
                if (((nb_reg == 2'd0) && (cur_row_reg == '0)) ||
                    ((nb_reg == 2'd1) && (cur_row_reg == LAST_RC)) ||
                    ((nb_reg == 2'd2) && (cur_col_reg == '0)))
                begin
                    nb_next = nb_reg + 2'd1;
                end
            end
            spu_pkg::S_Q_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = SITE_W'(query_reg);
            end
            spu_pkg::S_Q_EX:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    odo_out_next    = in_range ? ram_q.odo : '0;
                    height_out_next = in_range ? ram_q.height[1:0] : 2'd0;
                    bnd_out_next    = bound_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spu_pkg::S_CLEAR;
            phase_reg     <= spu_pkg::PH_A;
            core_reg      <= '0;
            restart_reg   <= 1'b0;
            clr_reg       <= '0;
            load_reg      <= '0;
            nb_reg        <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            bound_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            bnd_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            if (cfg_valid)
            begin
                core_reg <= cfg_data;
            end
            restart_reg   <= restart_next;
            clr_reg       <= clr_next;
            load_reg      <= load_next;
            nb_reg        <= nb_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            bound_reg     <= bound_next;
            out_valid_reg <= out_valid_next;
            bnd_out_reg   <= bnd_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_a_reg      <= amt_a_next;
        amt_b_reg      <= amt_b_next;
        query_reg      <= query_next;
        cur_row_reg    <= cur_row_next;
        cur_col_reg    <= cur_col_next;
        tgt_row_reg    <= tgt_row_next;
        tgt_col_reg    <= tgt_col_next;
        grains_reg     <= grains_next;
        odo_out_reg    <= odo_out_next;
        height_out_reg <= height_out_next;
    end

    `SPU_ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_MAX)
    `SPU_ASSERT_ALWAYS(a_idle_empty, (state_reg != spu_pkg::S_IDLE) || (count_reg == '0))
    `SPU_ASSERT_NEXT(a_hold_result, (state_reg == spu_pkg::S_Q_EX) && out_valid_reg && !out_ready, state_reg == spu_pkg::S_Q_EX)
    `SPU_ASSERT_NEXT(a_result_once, (state_reg == spu_pkg::S_Q_EX) && (!out_valid_reg || out_ready), out_valid_reg)
endmodule
